>>> rtl/avm_pkg.sv
// -----------------------------------------------------------------------------
// avm_pkg: shared types and constants of the voice table audio mixer
// Item and result codes, engine states, reset values and the gain saturation.
// -----------------------------------------------------------------------------
package avm_pkg;

  localparam int MAX_VOICES_DEF = 256;
  localparam int MIX_FRAMES_DEF = 4096;

  localparam logic [15:0] MASTER_RESET    = 16'd32768;
  localparam logic [12:0] MAX_WRITE_RESET = 13'((48000 / 60) * 3);
  localparam logic [24:0] PLAYED_MAX      = 25'h1FFFFFF;

  // Configuration register indexes
  localparam logic CFG_MASTER    = 1'b0;
  localparam logic CFG_MAX_WRITE = 1'b1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_ADVANCE,
    KIND_MIX,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NO_VOICE,
    ST_OUT_WINDOW
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_ADV_RD,
    S_ADV_WR,
    S_MIX_RD,
    S_MIX_CHK,
    S_MIX_MUL,
    S_MIX_ADD,
    S_READ_RD,
    S_READ_WB
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [23:0]        voice_length;
    logic [15:0]        voice_gain;
    logic [15:0]        advance_frames;
    logic [7:0]         slot;
    logic [11:0]        frame_offset;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } item_t;

  // Head of the item queue as seen by the engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [15:0] master_volume;
    logic [12:0] max_write_frames;
  } cfg_t;

  // Drop the Q19.30 fraction and saturate to a signed 16-bit sample
  function automatic logic [15:0] scale_sat(input logic [48:0] prod, input logic neg);
    logic [18:0] q;
    logic [18:0] nq;
    q  = prod[48:30];
    nq = 19'd0 - q;
    if (neg) begin
      scale_sat = (q > 19'd32768) ? 16'h8000 : nq[15:0];
    end else begin
      scale_sat = (q > 19'd32767) ? 16'h7FFF : q[15:0];
    end
  endfunction

endpackage

>>> rtl/avm_front.sv
// -----------------------------------------------------------------------------
// avm_front: item intake
// Two-entry queue that takes items and hands them to the engine in order.
// -----------------------------------------------------------------------------
module avm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  avm_pkg::item_t      item_in,
  output avm_pkg::queue_head_t head,
  input  logic                pop
);
  import avm_pkg::*;

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        take;

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall;
  assign take       = pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.item  = entries[rd_ptr];

  // Store incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(take);
    end
  end

endmodule

>>> rtl/avm_back.sv
// -----------------------------------------------------------------------------
// avm_back: mixing engine
// Sequencer over the voice table and the stereo mix store, with result register.
// -----------------------------------------------------------------------------
module avm_back #(
  parameter int MAX_VOICES = avm_pkg::MAX_VOICES_DEF,
  parameter int MIX_FRAMES = avm_pkg::MIX_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  avm_pkg::queue_head_t head,
  output logic                 pop,
  input  avm_pkg::cfg_t        cfg,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [1:0]           status,
  output logic [8:0]           active_voices,
  output logic [23:0]          source_frame,
  output logic signed [15:0]   mix_left,
  output logic signed [15:0]   mix_right
);
  import avm_pkg::*;

  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int AW = $clog2(MIX_FRAMES);
  localparam logic [AW-1:0] LAST_FRAME = AW'(MIX_FRAMES - 1);
  localparam logic [CW-1:0] MAX_COUNT  = CW'(MAX_VOICES);

  state_t state, state_next;

  // Voice table: length, played, gain
  logic [64:0] tbl_mem [MAX_VOICES];
  logic [64:0] tbl_rdata;
  logic [VW-1:0] tbl_raddr, tbl_waddr;
  logic [64:0] tbl_wdata;
  logic        tbl_we;

  // Mix store: left in the upper half, right in the lower
  logic [31:0] store_mem [MIX_FRAMES];
  logic [31:0] store_rdata;
  logic [AW-1:0] store_raddr, store_waddr;
  logic [31:0] store_wdata;
  logic        store_we;

  logic [CW-1:0] count, adv_count, idx, n;
  logic [AW-1:0] clr;
  item_t         cur;
  logic [32:0]   prod1_l, prod1_r;
  logic [48:0]   prod2_l, prod2_r;
  logic          neg_l, neg_r;
  logic [23:0]   src_q;

  logic          done;
  status_t       r_status;
  logic [CW-1:0] r_count;
  logic [23:0]   r_src;
  logic [15:0]   r_left, r_right;

  // Decoded fields of the voice table entry and checks on the current item
  logic [23:0] t_len;
  logic [24:0] t_played;
  logic [15:0] t_gain;
  logic [25:0] adv_sum;
  logic [24:0] adv_played;
  logic        keep;
  logic        full;
  logic        slot_missing;
  logic        off_beyond;
  logic [24:0] win_raw, win;
  logic        off_outside;
  logic [23:0] src_now;
  logic [16:0] mag_l, mag_r;
  logic [15:0] sc_l, sc_r;
  logic [15:0] sum_l, sum_r;

  assign t_len    = tbl_rdata[64:41];
  assign t_played = tbl_rdata[40:16];
  assign t_gain   = tbl_rdata[15:0];

  assign adv_sum    = {1'b0, t_played} + {10'd0, cur.advance_frames};
  assign adv_played = (idx < adv_count) ?
                      (adv_sum > {1'b0, PLAYED_MAX} ? PLAYED_MAX : adv_sum[24:0]) : t_played;
  assign keep       = adv_played < {1'b0, t_len};

  assign full         = (count >= MAX_COUNT);
  assign slot_missing = (32'(cur.slot) >= 32'(count));
  assign off_beyond   = (32'(cur.frame_offset) >= 32'(MIX_FRAMES));
  assign win_raw      = (t_played < {1'b0, t_len}) ? ({1'b0, t_len} - t_played) : 25'd0;
  assign win          = (win_raw > {12'd0, cfg.max_write_frames}) ?
                        {12'd0, cfg.max_write_frames} : win_raw;
  assign off_outside  = ({13'd0, cur.frame_offset} >= win);
  assign src_now      = 24'(t_played + {13'd0, cur.frame_offset});

  assign mag_l = cur.left_in[15]  ? (17'd0 - {1'b1, cur.left_in})  : {1'b0, cur.left_in};
  assign mag_r = cur.right_in[15] ? (17'd0 - {1'b1, cur.right_in}) : {1'b0, cur.right_in};

  assign sc_l  = scale_sat(prod2_l, neg_l);
  assign sc_r  = scale_sat(prod2_r, neg_r);
  assign sum_l = store_rdata[31:16] + sc_l;
  assign sum_r = store_rdata[15:0]  + sc_r;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr == LAST_FRAME) state_next = S_IDLE;
      S_IDLE: begin
        if (head.valid && !result_valid) begin
          unique case (head.item.kind)
            KIND_START:   state_next = S_START;
            KIND_ADVANCE: state_next = S_ADV_RD;
            KIND_MIX:     state_next = S_MIX_RD;
            KIND_READ:    state_next = S_READ_RD;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_START:   state_next = S_IDLE;
      S_ADV_RD:  state_next = (idx == count) ? S_IDLE : S_ADV_WR;
      S_ADV_WR:  state_next = S_ADV_RD;
      S_MIX_RD:  state_next = slot_missing ? S_IDLE : S_MIX_CHK;
      S_MIX_CHK: state_next = (off_beyond || off_outside) ? S_IDLE : S_MIX_MUL;
      S_MIX_MUL: state_next = S_MIX_ADD;
      S_MIX_ADD: state_next = S_IDLE;
      S_READ_RD: state_next = off_beyond ? S_IDLE : S_READ_WB;
      S_READ_WB: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory controls and result
  always_comb begin
    pop         = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = VW'(count);
    tbl_wdata   = {cur.voice_length, 25'd0, cur.voice_gain};
    tbl_raddr   = VW'(cur.slot);
    store_raddr = AW'(cur.frame_offset);
    store_waddr = AW'(cur.frame_offset);
    store_we    = 1'b0;
    store_wdata = 32'd0;
    done        = 1'b0;
    r_status    = ST_OK;
    r_count     = count;
    r_src       = 24'd0;
    r_left      = 16'd0;
    r_right     = 16'd0;
    unique case (state)
      S_CLEAR: begin
        store_we    = 1'b1;
        store_waddr = clr;
      end
      S_IDLE: pop = head.valid && !result_valid;
      S_START: begin
        done = 1'b1;
        if (full) begin
          r_status = ST_FULL;
        end else begin
          tbl_we  = 1'b1;
          r_count = count + CW'(1);
        end
      end
      S_ADV_RD: begin
        tbl_raddr = VW'(idx);
        if (idx == count) begin
          done    = 1'b1;
          r_count = n;
        end
      end
      S_ADV_WR: begin
        tbl_waddr = VW'(n);
        tbl_wdata = {t_len, adv_played, t_gain};
        tbl_we    = keep;
      end
      S_MIX_RD: begin
        if (slot_missing) begin
          done     = 1'b1;
          r_status = ST_NO_VOICE;
        end
      end
      S_MIX_CHK: begin
        r_src = src_now;
        if (off_beyond) begin
          done     = 1'b1;
          r_status = ST_OUT_WINDOW;
        end else if (off_outside) begin
          done     = 1'b1;
          r_status = ST_OUT_WINDOW;
          r_left   = store_rdata[31:16];
          r_right  = store_rdata[15:0];
        end
      end
      S_MIX_MUL: ;
      S_MIX_ADD: begin
        done        = 1'b1;
        r_src       = src_q;
        r_left      = sum_l;
        r_right     = sum_r;
        store_we    = 1'b1;
        store_wdata = {sum_l, sum_r};
      end
      S_READ_RD: begin
        if (off_beyond) begin
          done     = 1'b1;
          r_status = ST_OUT_WINDOW;
        end
      end
      S_READ_WB: begin
        done     = 1'b1;
        r_left   = store_rdata[31:16];
        r_right  = store_rdata[15:0];
        store_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Voice table memory
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  // Mix store memory
  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    store_rdata <= store_mem[store_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      count        <= '0;
      adv_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (state == S_START && !full) count <= count + CW'(1);
      if (state == S_ADV_RD && idx == count) begin
        count     <= n;
        adv_count <= n;
      end
      if (done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
      idx <= '0;
      n   <= '0;
    end
    if (state == S_ADV_WR) begin
      idx <= idx + CW'(1);
      if (keep) n <= n + CW'(1);
    end
    if (state == S_MIX_CHK) begin
      prod1_l <= mag_l * t_gain;
      prod1_r <= mag_r * t_gain;
      neg_l   <= cur.left_in[15];
      neg_r   <= cur.right_in[15];
      src_q   <= src_now;
    end
    if (state == S_MIX_MUL) begin
      prod2_l <= prod1_l * cfg.master_volume;
      prod2_r <= prod1_r * cfg.master_volume;
    end
    if (done) begin
      status        <= r_status;
      active_voices <= 9'(r_count);
      source_frame  <= r_src;
      mix_left      <= r_left;
      mix_right     <= r_right;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT) else $error("voice count beyond table depth");

  a_adv_bound: assert property (@(posedge clk) disable iff (rst)
    adv_count <= count) else $error("advanced count beyond voice count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> !result_valid) else $error("result overwritten before taken");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!result_valid && !pop)) else $error("item handled during clear");

endmodule

>>> rtl/voice_table_audio_mixer.sv
// -----------------------------------------------------------------------------
// voice_table_audio_mixer: stereo PCM mixer with a voice table
// Queue in front, sequencing engine behind, configuration registers here.
// -----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  item     | item_valid / item_stall  | kind .. right_in
//  result   | result_valid / result_stall | status .. mix_right
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  The engine takes one item at a time and walks the voice table and mix
//  store for it; an advance walks every voice in the table.
//  After reset a clearing pass zeroes the mix store; items queue up
//  meanwhile, configuration writes are always taken.
//  A stalled result holds the engine; the two-entry queue keeps taking
//  items until it is full.
// -----------------------------------------------------------------------------
module voice_table_audio_mixer #(
  parameter int MAX_VOICES = avm_pkg::MAX_VOICES_DEF,
  parameter int MIX_FRAMES = avm_pkg::MIX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         kind,
  input  logic [23:0]        voice_length,
  input  logic [15:0]        voice_gain,
  input  logic [15:0]        advance_frames,
  input  logic [7:0]         slot,
  input  logic [11:0]        frame_offset,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [8:0]         active_voices,
  output logic [23:0]        source_frame,
  output logic signed [15:0] mix_left,
  output logic signed [15:0] mix_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import avm_pkg::*;

  cfg_t        cfg;
  item_t       item_in;
  queue_head_t head;
  logic        pop;

  assign cfg_ready = 1'b1;

  // Gather the input transaction
  always_comb begin
    item_in.kind           = kind_t'(kind);
    item_in.voice_length   = voice_length;
    item_in.voice_gain     = voice_gain;
    item_in.advance_frames = advance_frames;
    item_in.slot           = slot;
    item_in.frame_offset   = frame_offset;
    item_in.left_in        = left_in;
    item_in.right_in       = right_in;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_volume    <= MASTER_RESET;
      cfg.max_write_frames <= MAX_WRITE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASTER:    cfg.master_volume    <= cfg_data;
        CFG_MAX_WRITE: cfg.max_write_frames <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  avm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .head       (head),
    .pop        (pop)
  );

  avm_back #(
    .MAX_VOICES (MAX_VOICES),
    .MIX_FRAMES (MIX_FRAMES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .cfg           (cfg),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .active_voices (active_voices),
    .source_frame  (source_frame),
    .mix_left      (mix_left),
    .mix_right     (mix_right)
  );

endmodule

>>> sim/mixer_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// mixer_checker: scoreboard for the voice table audio mixer
// Watches the item, result and configuration channels, keeps its own copy of
// the voice table, mix store and registers, predicts one result per item and
// compares every result field against the oldest prediction.
// -----------------------------------------------------------------------------
module mixer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [1:0]         kind,
  input  logic [23:0]        voice_length,
  input  logic [15:0]        voice_gain,
  input  logic [15:0]        advance_frames,
  input  logic [7:0]         slot,
  input  logic [11:0]        frame_offset,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         status,
  input  logic [8:0]         active_voices,
  input  logic [23:0]        source_frame,
  input  logic signed [15:0] mix_left,
  input  logic signed [15:0] mix_right,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import avm_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [8:0]  active;
    logic [23:0] src_frame;
    logic [15:0] left;
    logic [15:0] right;
  } mix_result_t;

  logic [23:0] voice_len  [MAX_VOICES_DEF];
  logic [24:0] voice_pos  [MAX_VOICES_DEF];
  logic [15:0] voice_amp  [MAX_VOICES_DEF];
  logic [15:0] store_l    [MIX_FRAMES_DEF];
  logic [15:0] store_r    [MIX_FRAMES_DEF];
  int unsigned n_voices;
  int unsigned n_advanced;
  logic [15:0] master_gain;
  logic [12:0] window_cap;
  mix_result_t awaited[$];

  assign pending = awaited.size();

  // Scale one sample by both Q1.15 gains, truncate toward zero and saturate
  function automatic logic [15:0] gain_sample(logic signed [15:0] s, logic [15:0] vg,
                                              logic [15:0] mg);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
    q = (mag * vg * mg) >> 30;
    if (s < 0)
      return (q > 32768) ? 16'h8000 : 16'(-q);
    return (q > 32767) ? 16'h7FFF : 16'(q);
  endfunction

  // Apply one item to the mixer copy and work out its result
  task automatic mix_item(output mix_result_t r);
    logic [24:0] p;
    logic [24:0] win;
    int unsigned n;
    r = '0;
    case (kind_t'(kind))
      KIND_START: begin
        if (n_voices >= MAX_VOICES_DEF) begin
          r.status = ST_FULL;
        end else begin
          voice_len[n_voices] = voice_length;
          voice_pos[n_voices] = '0;
          voice_amp[n_voices] = voice_gain;
          n_voices++;
        end
      end
      KIND_ADVANCE: begin
        for (int i = 0; i < n_advanced && i < n_voices; i++) begin
          p = voice_pos[i] + advance_frames;
          voice_pos[i] = (p < voice_pos[i]) ? PLAYED_MAX : p;
        end
        n = 0;
        for (int i = 0; i < n_voices; i++) begin
          if (voice_pos[i] < voice_len[i]) begin
            voice_len[n] = voice_len[i];
            voice_pos[n] = voice_pos[i];
            voice_amp[n] = voice_amp[i];
            n++;
          end
        end
        n_voices = n;
        n_advanced = n;
      end
      KIND_MIX: begin
        if (slot >= n_voices) begin
          r.status = ST_NO_VOICE;
        end else begin
          win = (voice_pos[slot] < voice_len[slot]) ? voice_len[slot] - voice_pos[slot] : '0;
          if (win > window_cap) win = window_cap;
          r.src_frame = 24'(voice_pos[slot] + frame_offset);
          if (frame_offset >= win) begin
            r.status = ST_OUT_WINDOW;
          end else begin
            store_l[frame_offset] += gain_sample(left_in, voice_amp[slot], master_gain);
            store_r[frame_offset] += gain_sample(right_in, voice_amp[slot], master_gain);
          end
          r.left  = store_l[frame_offset];
          r.right = store_r[frame_offset];
        end
      end
      default: begin
        r.left  = store_l[frame_offset];
        r.right = store_r[frame_offset];
        store_l[frame_offset] = '0;
        store_r[frame_offset] = '0;
      end
    endcase
    r.active = 9'(n_voices);
  endtask

  always @(posedge clk) begin
    mix_result_t want;
    mix_result_t got;
    if (rst) begin
      n_voices    = 0;
      n_advanced  = 0;
      master_gain = MASTER_RESET;
      window_cap  = MAX_WRITE_RESET;
      for (int i = 0; i < MIX_FRAMES_DEF; i++) begin
        store_l[i] = '0;
        store_r[i] = '0;
      end
      awaited.delete();
      fail_count = 0;
    end else begin
      // Compare an accepted result with the oldest prediction
      if (result_valid && !result_stall) begin
        got = '{status_t'(status), active_voices, source_frame, mix_left, mix_right};
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: %p", got);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result differs: expected %p, actual %p", want, got);
          end
        end
      end
      // Predict from each accepted item
      if (item_valid && !item_stall) begin
        mix_item(want);
        awaited.push_back(want);
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MASTER) master_gain = cfg_data;
        else window_cap = cfg_data[12:0];
      end
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb: testbench top for the voice table audio mixer
// Drives directed and random item sequences under varied idling and a long
// result hold-off, writes both registers between phases, and reports the
// verdict from the checker's failure count.
// -----------------------------------------------------------------------------
module tb;
  import avm_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         kind = KIND_START;
  logic [23:0]        voice_length = '0;
  logic [15:0]        voice_gain = '0;
  logic [15:0]        advance_frames = '0;
  logic [7:0]         slot = '0;
  logic [11:0]        frame_offset = '0;
  logic signed [15:0] left_in = '0;
  logic signed [15:0] right_in = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         status;
  logic [8:0]         active_voices;
  logic [23:0]        source_frame;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_MASTER;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  logic               hold_go = 1'b0;
  logic               hold_on = 1'b0;

  always #5 clk = ~clk;

  voice_table_audio_mixer DUT (.*);
  mixer_checker u_checker (.*);

  // Randomly stall the result side, or hold it off entirely
  always @(posedge clk)
    result_stall <= hold_on || ($urandom_range(99) < recv_idle);

  // Long hold-off so the item queue fills and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Offer one item and wait for its transaction, then maybe idle
  task automatic send(kind_t k, logic [23:0] len, logic [15:0] gain, logic [15:0] adv,
                      logic [7:0] s, logic [11:0] off, logic [15:0] l, logic [15:0] r);
    kind <= k;
    voice_length <= len;
    voice_gain <= gain;
    advance_frames <= adv;
    slot <= s;
    frame_offset <= off;
    left_in <= l;
    right_in <= r;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Write one register once the mixer has drained
  task automatic write_reg(logic idx, logic [15:0] data);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic over a few voices and a small frame range
  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20)
      send(KIND_START, ($urandom_range(99) < 70) ? 24'($urandom_range(60)) : 24'($urandom),
           16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom), 16'($urandom),
           16'($urandom));
    else if (pick < 35)
      send(KIND_ADVANCE, 24'($urandom), 16'($urandom),
           ($urandom_range(99) < 80) ? 16'($urandom_range(30)) : 16'($urandom),
           8'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
    else if (pick < 80)
      send(KIND_MIX, 24'($urandom), 16'($urandom), 16'($urandom),
           ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom),
           ($urandom_range(99) < 80) ? 12'($urandom_range(31)) : 12'($urandom),
           16'($urandom), 16'($urandom));
    else
      send(KIND_READ, 24'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
           ($urandom_range(99) < 80) ? 12'($urandom_range(31)) : 12'($urandom),
           16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every kind, window and missing-voice cases
    send(KIND_START, 24'd0, 16'd0, 16'd0, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_START, 24'hFFFFFF, 16'hFFFF, 16'd0, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_START, 24'd30, 16'h8000, 16'd0, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'd0, 16'h7FFF, 16'h8000);
    send(KIND_ADVANCE, 24'd0, 16'd0, 16'd0, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'd0, 16'h7FFF, 16'h8000);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'hFFF, 16'd1, 16'd1);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd1, 12'd29, 16'hFFFF, 16'h0001);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd1, 12'd30, 16'd5, 16'd5);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd255, 12'd0, 16'd5, 16'd5);
    send(KIND_READ, 24'd0, 16'd0, 16'd0, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_READ, 24'd0, 16'd0, 16'd0, 8'd0, 12'hFFF, 16'd0, 16'd0);
    send(KIND_ADVANCE, 24'd0, 16'd0, 16'hFFFF, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'd29, 16'h8000, 16'h7FFF);
    write_reg(CFG_MASTER, 16'hFFFF);
    write_reg(CFG_MAX_WRITE, 16'd4096);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'd1, 16'h8000, 16'h7FFF);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd0, 12'd4095, 16'h7FFF, 16'h8000);
    send(KIND_READ, 24'd0, 16'd0, 16'd0, 8'd0, 12'd1, 16'd0, 16'd0);
    send(KIND_READ, 24'd0, 16'd0, 16'd0, 8'd0, 12'd4095, 16'd0, 16'd0);

    // Sender idles less than the receiver, with a long hold-off early on
    write_reg(CFG_MASTER, 16'($urandom));
    write_reg(CFG_MAX_WRITE, 16'($urandom_range(1, 4096)));
    send_idle = 34;
    recv_idle = 53;
    hold_go <= 1'b1;
    repeat (60) random_item();

    // Swap the idling, zero gain and zero window
    write_reg(CFG_MASTER, 16'd0);
    write_reg(CFG_MAX_WRITE, 16'd0);
    send_idle = 53;
    recv_idle = 34;
    repeat (30) random_item();
    write_reg(CFG_MASTER, MASTER_RESET);
    write_reg(CFG_MAX_WRITE, 16'd1);
    repeat (30) random_item();

    // No idling: fill the table past full, then flush it
    write_reg(CFG_MAX_WRITE, 16'hFFFF);
    send_idle = 0;
    recv_idle = 0;
    repeat (260) send(KIND_START, 24'($urandom_range(1, 3)), 16'($urandom), 16'd0, 8'd0,
                      12'd0, 16'd0, 16'd0);
    send(KIND_MIX, 24'd0, 16'd0, 16'd0, 8'd255, 12'd0, 16'h7FFF, 16'h7FFF);
    send(KIND_ADVANCE, 24'd0, 16'd0, 16'hFFFF, 8'd0, 12'd0, 16'd0, 16'd0);
    send(KIND_ADVANCE, 24'd0, 16'd0, 16'hFFFF, 8'd0, 12'd0, 16'd0, 16'd0);
    write_reg(CFG_MAX_WRITE, MAX_WRITE_RESET);
    repeat (60) random_item();

    // Drain and give the verdict
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0)
      $display("voice_table_audio_mixer: match");
    else
      $display("voice_table_audio_mixer: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("voice_table_audio_mixer: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/avm_pkg.sv
rtl/avm_front.sv
rtl/avm_back.sv
rtl/voice_table_audio_mixer.sv
sim/mixer_checker.sv
sim/tb.sv
